// ----- src/assert_macros.svh -----
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition implies another in the next cycle, checked through reset too
`define ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/tbfr_pkg.sv -----
package tbfr_pkg;

   // telnet protocol bytes
   localparam logic [7:0] BYTE_IAC  = 8'd255;
   localparam logic [7:0] BYTE_WILL = 8'd251;
   localparam logic [7:0] BYTE_WONT = 8'd252;
   localparam logic [7:0] BYTE_DONT = 8'd254;
   localparam logic [7:0] OPT_MIN   = 8'd250;

   localparam logic [31:0] BASE_RESET = 32'h0806_0000;

   // results one received byte can cause
   localparam int RES_SLOTS = 3;
   localparam int SLOT_W    = $clog2(RES_SLOTS);

   // default depth of the queue between parser and result stage
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_TEXT  = 2'd1,
      KIND_WORD  = 2'd2,
      KIND_DONE  = 2'd3
   } result_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE          = 3'd0,
      PH_IAC           = 3'd1,
      PH_OPT           = 3'd2,
      PH_WONT          = 3'd3,
      PH_WONT_IAC      = 3'd4,
      PH_WONT_IAC_DONT = 3'd5
   } parse_phase_type;

   typedef struct packed {
      result_kind_type kind;
      logic [7:0]      reply_option;
      logic [7:0]      reply_value;
      logic [7:0]      text_byte;
      logic [31:0]     word_data;
      logic [31:0]     word_address;
      logic [31:0]     file_size;
   } result_type;

   // all results of one byte, slot 0 first
   typedef struct packed {
      result_type [RES_SLOTS-1:0] res;
      logic [SLOT_W-1:0]          count;
   } bundle_type;

endpackage

// ----- src/tbfr_front.sv -----
module tbfr_front import tbfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data_byte,
   input  logic        cfg_we,
   input  logic [31:0] cfg_base,
   output bundle_type  bundle
);

   logic            bin_ff, bin_in;
   parse_phase_type phase_ff, phase_in;
   logic [7:0]      opt_ff, opt_in;
   logic [23:0]     pack_ff, pack_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [31:0]     addr_ff, addr_in;
   logic [31:0]     base_ff;

   parse_phase_type ph, ph2;
   logic            done;
   logic [2:0][7:0] data_q;
   logic [1:0]      data_n;
   bundle_type      bundle_in;

   // parser state, advanced on every accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff   <= 1'b0;
         phase_ff <= PH_IDLE;
         opt_ff   <= '0;
         pack_ff  <= '0;
         cnt_ff   <= '0;
         addr_ff  <= BASE_RESET;
         base_ff  <= BASE_RESET;
      end else begin
         if (cfg_we) begin
            base_ff <= cfg_base;
         end
         if (accept) begin
            bin_ff   <= bin_in;
            phase_ff <= phase_in;
            opt_ff   <= opt_in;
            pack_ff  <= pack_in;
            cnt_ff   <= cnt_in;
            addr_ff  <= addr_in;
         end
      end
   end

   // classify the byte and build its results
   always_comb begin
      bin_in    = bin_ff;
      phase_in  = phase_ff;
      opt_in    = opt_ff;
      pack_in   = pack_ff;
      cnt_in    = cnt_ff;
      addr_in   = addr_ff;
      bundle_in = '0;
      data_q    = '0;
      data_n    = 2'd0;
      done      = 1'b0;

      // end-of-file phases only exist in binary mode
      ph = phase_ff;
      if (!bin_ff && phase_ff != PH_IDLE && phase_ff != PH_IAC && phase_ff != PH_OPT) begin
         ph = PH_IDLE;
      end

      // end-of-file pattern; a break falls back to an earlier phase
      ph2 = ph;
      unique case (ph)
         PH_WONT: begin
            if (data_byte == BYTE_IAC) begin
               phase_in = PH_WONT_IAC;
               done     = 1'b1;
            end else begin
               ph2 = PH_IDLE;
            end
         end
         PH_WONT_IAC: begin
            if (data_byte == BYTE_DONT) begin
               phase_in = PH_WONT_IAC_DONT;
               done     = 1'b1;
            end else begin
               ph2 = PH_IAC;
            end
         end
         PH_WONT_IAC_DONT: begin
            if (data_byte == 8'd0) begin
               bundle_in.res[0].kind         = KIND_REPLY;
               bundle_in.res[0].reply_option = BYTE_WONT;
               bundle_in.res[1].kind         = KIND_REPLY;
               bundle_in.res[1].reply_option = BYTE_DONT;
               bundle_in.res[2].kind         = KIND_DONE;
               bundle_in.res[2].file_size    = addr_ff - base_ff;
               bundle_in.count               = SLOT_W'(3);
               bin_in   = 1'b0;
               pack_in  = '0;
               cnt_in   = '0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end else begin
               opt_in = BYTE_DONT;
               ph2    = PH_OPT;
            end
         end
         default: ;
      endcase

      // ordinary parse of idle, after iac, after option
      if (!done) begin
         unique case (ph2)
            PH_IDLE: begin
               phase_in = PH_IDLE;
               if (data_byte == BYTE_IAC) begin
                  phase_in = PH_IAC;
               end else if (bin_ff) begin
                  data_q[0] = data_byte;
                  data_n    = 2'd1;
               end else begin
                  bundle_in.res[0].kind      = KIND_TEXT;
                  bundle_in.res[0].text_byte = data_byte;
                  bundle_in.count            = SLOT_W'(1);
               end
            end
            PH_IAC: begin
               phase_in = PH_IDLE;
               if (bin_ff && data_byte == BYTE_IAC) begin
                  data_q[0] = BYTE_IAC;
                  data_n    = 2'd1;
               end else if (data_byte > OPT_MIN) begin
                  opt_in   = data_byte;
                  phase_in = PH_OPT;
               end else if (bin_ff) begin
                  data_q[0] = BYTE_IAC;
                  data_q[1] = data_byte;
                  data_n    = 2'd2;
               end else begin
                  bundle_in.res[0].kind      = KIND_TEXT;
                  bundle_in.res[0].text_byte = BYTE_IAC;
                  bundle_in.res[1].kind      = KIND_TEXT;
                  bundle_in.res[1].text_byte = data_byte;
                  bundle_in.count            = SLOT_W'(2);
               end
            end
            PH_OPT: begin
               phase_in = PH_IDLE;
               if (!bin_ff) begin
                  if (data_byte == 8'd0) begin
                     if (opt_in == BYTE_WILL) begin
                        bin_in  = 1'b1;
                        addr_in = base_ff;
                        pack_in = '0;
                        cnt_in  = '0;
                     end else begin
                        bundle_in.res[0].kind         = KIND_REPLY;
                        bundle_in.res[0].reply_option = opt_in;
                        bundle_in.count               = SLOT_W'(1);
                     end
                  end
               end else if (data_byte == 8'd0) begin
                  if (opt_in == BYTE_WONT) begin
                     phase_in = PH_WONT;
                  end
               end else begin
                  data_q[0] = BYTE_IAC;
                  data_q[1] = opt_in;
                  data_q[2] = data_byte;
                  data_n    = 2'd3;
               end
            end
            default: ;
         endcase
      end

      // little-endian word packing, at most one word per byte
      for (int i = 0; i < RES_SLOTS; i++) begin
         if (i < int'(data_n)) begin
            if (cnt_in == 2'd3) begin
               bundle_in.res[0].kind         = KIND_WORD;
               bundle_in.res[0].word_data    = {data_q[i], pack_in};
               bundle_in.res[0].word_address = addr_in;
               bundle_in.count               = SLOT_W'(1);
               addr_in = addr_in + 32'd4;
               pack_in = '0;
               cnt_in  = '0;
            end else begin
               unique case (cnt_in)
                  2'd0:    pack_in[7:0]   = data_q[i];
                  2'd1:    pack_in[15:8]  = data_q[i];
                  default: pack_in[23:16] = data_q[i];
               endcase
               cnt_in = cnt_in + 2'd1;
            end
         end
      end
   end

   assign bundle = bundle_in;

endmodule

// ----- src/tbfr_queue.sv -----
module tbfr_queue import tbfr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output bundle_type head,
   output logic       empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type         mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // pointer advance with wrap at any depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

endmodule

// ----- src/tbfr_back.sv -----
module tbfr_back import tbfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_empty,
   input  bundle_type  q_head,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_reply_option,
   output logic [7:0]  rsp_reply_value,
   output logic [7:0]  rsp_text_byte,
   output logic [31:0] rsp_word_data,
   output logic [31:0] rsp_word_address,
   output logic [31:0] rsp_file_size,
   output logic        rsp_last
);

   bundle_type        bundle_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic              valid_ff;

   result_type cur;
   logic       is_last, take, finish, load;

   // serialize the held bundle one result per transfer
   assign cur     = bundle_ff.res[idx_ff];
   assign is_last = (idx_ff == bundle_ff.count - 1'b1);
   assign take    = valid_ff && rsp_pop;
   assign finish  = take && is_last;
   assign load    = (!valid_ff || finish) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (finish) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // bundle payload
   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= q_head;
      end
   end

   assign q_pop            = load;
   assign rsp_empty        = !valid_ff;
   assign rsp_result_kind  = cur.kind;
   assign rsp_reply_option = cur.reply_option;
   assign rsp_reply_value  = cur.reply_value;
   assign rsp_text_byte    = cur.text_byte;
   assign rsp_word_data    = cur.word_data;
   assign rsp_word_address = cur.word_address;
   assign rsp_file_size    = cur.file_size;
   assign rsp_last         = is_last;

endmodule

// ----- src/telnet_binary_file_receiver.sv -----
// Telnet receive path with binary file capture.
// Request side: a queue-style input; one received byte is taken per transfer
// (req_push while req_full is low). Result side: a queue-style output; the
// oldest result sits on the rsp_ ports while rsp_empty is low and leaves on
// rsp_pop. Each byte causes zero to three results (reply command, shell text
// byte, file word with address, file done with size); rsp_last marks the
// final result of a byte. csr_write_en loads the file base address.
// A byte's results pass through the bundle queue and the result stage register.
// Throughput: one byte per cycle at the input while req_full is low and one
// result per cycle at the output while rsp_pop is high; the parser classifies
// a byte combinationally and the result stage drains one result per cycle, so
// bytes causing several results fill the bundle queue between them and
// req_full rises when it holds DEPTH bytes.
// A stalled receiver (rsp_pop low) holds the current result, the queue
// absorbs up to DEPTH more result-bearing bytes, then req_full stops input.
// Reset: synchronous; text mode, empty queue, base address 0x0806_0000.
module telnet_binary_file_receiver import tbfr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_reply_option,
   output logic [7:0]  rsp_reply_value,
   output logic [7:0]  rsp_text_byte,
   output logic [31:0] rsp_word_data,
   output logic [31:0] rsp_word_address,
   output logic [31:0] rsp_file_size,
   output logic        rsp_last,
   input  logic        csr_write_en,
   input  logic [31:0] csr_file_base_address
);

`include "assert_macros.svh"

   bundle_type bundle, q_head;
   logic       accept, q_full, q_push, q_pop, q_empty;
   logic       rsp_is_done, rsp_not_word, word_zero;

   // input transfer and queue write
   assign accept   = req_push && !q_full;
   assign q_push   = accept && (bundle.count != '0);
   assign req_full = q_full;

   tbfr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .cfg_we    (csr_write_en),
      .cfg_base  (csr_file_base_address),
      .bundle    (bundle)
   );

   tbfr_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (bundle),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   tbfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_reply_option (rsp_reply_option),
      .rsp_reply_value  (rsp_reply_value),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_word_data    (rsp_word_data),
      .rsp_word_address (rsp_word_address),
      .rsp_file_size    (rsp_file_size),
      .rsp_last         (rsp_last)
   );

   // result qualifiers for the checks
   assign rsp_is_done  = !rsp_empty && (rsp_result_kind == KIND_DONE);
   assign rsp_not_word = !rsp_empty && (rsp_result_kind != KIND_WORD);
   assign word_zero    = (rsp_word_data == '0) && (rsp_word_address == '0);

   // checks
   `ASSERT_NEXT(a_reset_clears, reset, rsp_empty && !req_full, "reset left results or full")
   `ASSERT_ALWAYS(a_done_is_last, rsp_is_done |-> rsp_last, "file done not last")
   `ASSERT_ALWAYS(a_word_fields, rsp_not_word |-> word_zero, "word fields on non-word result")

endmodule

// ----- dv/tb.sv -----
`default_nettype none

module tb;
   import tbfr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_BYTES  = 90;

   // one expected result and its end-of-byte flag
   typedef struct {
      result_type fields;
      logic       last;
   } telnet_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_reply_option;
   logic [7:0]  rsp_reply_value;
   logic [7:0]  rsp_text_byte;
   logic [31:0] rsp_word_data;
   logic [31:0] rsp_word_address;
   logic [31:0] rsp_file_size;
   logic        rsp_last;
   logic        csr_write_en = 1'b0;
   logic [31:0] csr_file_base_address = 32'd0;

   // receiver model state
   logic            in_binary;
   parse_phase_type phase;
   logic [7:0]      held_opt;
   logic [23:0]     pack_bytes;
   logic [1:0]      pack_cnt;
   logic [31:0]     wr_addr;
   logic [31:0]     base_addr;

   telnet_result_type byte_results[$];
   telnet_result_type pending_results[$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int bytes_sent    = 0;
   int mismatch_count = 0;
   int cycle_count   = 0;

   telnet_binary_file_receiver dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_data_byte         (req_data_byte),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_reply_option      (rsp_reply_option),
      .rsp_reply_value       (rsp_reply_value),
      .rsp_text_byte         (rsp_text_byte),
      .rsp_word_data         (rsp_word_data),
      .rsp_word_address      (rsp_word_address),
      .rsp_file_size         (rsp_file_size),
      .rsp_last              (rsp_last),
      .csr_write_en          (csr_write_en),
      .csr_file_base_address (csr_file_base_address)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // receiver model
   // ---------------------------------------------------------------

   function automatic void add_result(result_kind_type kind, logic [7:0] opt,
                                      logic [7:0] txt, logic [31:0] word,
                                      logic [31:0] addr, logic [31:0] size);
      telnet_result_type r;
      r.fields.kind         = kind;
      r.fields.reply_option = opt;
      r.fields.reply_value  = 8'd0;
      r.fields.text_byte    = txt;
      r.fields.word_data    = word;
      r.fields.word_address = addr;
      r.fields.file_size    = size;
      r.last                = 1'b0;
      if (byte_results.size() < RES_SLOTS)
         byte_results.push_back(r);
   endfunction

   // little-endian packing of file bytes into words
   function automatic void pack_file_byte(logic [7:0] b);
      if (pack_cnt == 2'd3) begin
         add_result(KIND_WORD, 8'd0, 8'd0, {b, pack_bytes}, wr_addr, 32'd0);
         wr_addr    = wr_addr + 32'd4;
         pack_bytes = 24'd0;
         pack_cnt   = 2'd0;
      end else begin
         pack_bytes[8*pack_cnt +: 8] = b;
         pack_cnt = pack_cnt + 2'd1;
      end
   endfunction

   function automatic void reset_receiver_model();
      in_binary  = 1'b0;
      phase      = PH_IDLE;
      held_opt   = 8'd0;
      pack_bytes = 24'd0;
      pack_cnt   = 2'd0;
      base_addr  = BASE_RESET;
      wr_addr    = BASE_RESET;
   endfunction

   // parse one received byte and queue the results it causes
   function automatic void decode_telnet_byte(logic [7:0] b);
      parse_phase_type ph;
      bit reparse;
      ph = phase;
      reparse = 1'b1;
      byte_results.delete();
      while (reparse) begin
         reparse = 1'b0;
         if (ph > PH_WONT_IAC_DONT || (!in_binary && ph > PH_OPT))
            ph = PH_IDLE;
         case (ph)
            PH_IDLE: begin
               phase = PH_IDLE;
               if (b == BYTE_IAC)
                  phase = PH_IAC;
               else if (in_binary)
                  pack_file_byte(b);
               else
                  add_result(KIND_TEXT, 8'd0, b, 32'd0, 32'd0, 32'd0);
            end
            PH_IAC: begin
               phase = PH_IDLE;
               if (in_binary && b == BYTE_IAC) begin
                  pack_file_byte(BYTE_IAC);
               end else if (b > OPT_MIN) begin
                  held_opt = b;
                  phase = PH_OPT;
               end else if (in_binary) begin
                  pack_file_byte(BYTE_IAC);
                  pack_file_byte(b);
               end else begin
                  add_result(KIND_TEXT, 8'd0, BYTE_IAC, 32'd0, 32'd0, 32'd0);
                  add_result(KIND_TEXT, 8'd0, b, 32'd0, 32'd0, 32'd0);
               end
            end
            PH_OPT: begin
               phase = PH_IDLE;
               if (!in_binary) begin
                  if (b == 8'd0) begin
                     if (held_opt == BYTE_WILL) begin
                        in_binary  = 1'b1;
                        wr_addr    = base_addr;
                        pack_bytes = 24'd0;
                        pack_cnt   = 2'd0;
                     end else begin
                        add_result(KIND_REPLY, held_opt, 8'd0, 32'd0, 32'd0, 32'd0);
                     end
                  end
               end else if (b == 8'd0) begin
                  if (held_opt == BYTE_WONT)
                     phase = PH_WONT;
               end else begin
                  pack_file_byte(BYTE_IAC);
                  pack_file_byte(held_opt);
                  pack_file_byte(b);
               end
            end
            PH_WONT: begin
               if (b == BYTE_IAC) begin
                  phase = PH_WONT_IAC;
               end else begin
                  ph = PH_IDLE;
                  reparse = 1'b1;
               end
            end
            PH_WONT_IAC: begin
               if (b == BYTE_DONT) begin
                  phase = PH_WONT_IAC_DONT;
               end else begin
                  ph = PH_IAC;
                  reparse = 1'b1;
               end
            end
            default: begin
               if (b == 8'd0) begin
                  // end of file: echo both commands, then report the size
                  add_result(KIND_REPLY, BYTE_WONT, 8'd0, 32'd0, 32'd0, 32'd0);
                  add_result(KIND_REPLY, BYTE_DONT, 8'd0, 32'd0, 32'd0, 32'd0);
                  add_result(KIND_DONE, 8'd0, 8'd0, 32'd0, 32'd0, wr_addr - base_addr);
                  in_binary  = 1'b0;
                  pack_bytes = 24'd0;
                  pack_cnt   = 2'd0;
                  phase      = PH_IDLE;
               end else begin
                  held_opt = BYTE_DONT;
                  ph = PH_OPT;
                  reparse = 1'b1;
               end
            end
         endcase
      end
      if (byte_results.size() > 0)
         byte_results[byte_results.size()-1].last = 1'b1;
      foreach (byte_results[i])
         pending_results.push_back(byte_results[i]);
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // compare every result transfer with the oldest expectation
   always @(posedge clock) begin
      telnet_result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, got kind %0d",
                     $time, rsp_result_kind);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", want.fields.kind, rsp_result_kind);
            check_field("reply_option", want.fields.reply_option, rsp_reply_option);
            check_field("reply_value", want.fields.reply_value, rsp_reply_value);
            check_field("text_byte", want.fields.text_byte, rsp_text_byte);
            check_field("word_data", want.fields.word_data, rsp_word_data);
            check_field("word_address", want.fields.word_address, rsp_word_address);
            check_field("file_size", want.fields.file_size, rsp_file_size);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // random receiver stalls
   always @(negedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------

   // one byte transfer; entered and left at a falling edge, push left high
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      do
         @(posedge clock);
      while (req_full);
      decode_telnet_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_triple(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      send_byte(a);
      send_byte(b);
      send_byte(c);
   endtask

   task automatic end_file();
      send_triple(BYTE_IAC, BYTE_WONT, 8'd0);
      send_triple(BYTE_IAC, BYTE_DONT, 8'd0);
   endtask

   // base address write once the block has gone quiet
   task automatic write_file_base(input logic [31:0] value);
      req_push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_en          <= 1'b1;
      csr_file_base_address <= value;
      base_addr = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic test_text_path();
      send_byte(8'h00);
      // iac followed by an ordinary byte passes out as two text bytes
      send_byte(BYTE_IAC);
      send_byte(OPT_MIN);
   endtask

   task automatic test_reply_commands();
      send_triple(BYTE_IAC, 8'd253, 8'd0);
      // iac iac in text mode is read as option 255
      send_triple(BYTE_IAC, BYTE_IAC, 8'd0);
      // non-zero value drops the command
      send_triple(BYTE_IAC, BYTE_WONT, 8'd5);
   endtask

   task automatic test_binary_file();
      send_triple(BYTE_IAC, BYTE_WILL, 8'd0);
      // escaped 255 data byte
      send_byte(BYTE_IAC);
      send_byte(BYTE_IAC);
      // command with non-zero value is file data
      send_triple(BYTE_IAC, 8'd253, 8'd7);
      // other command with zero value is dropped
      send_triple(BYTE_IAC, 8'd253, 8'd0);
      // wont broken by iac plus ordinary byte: reparsed as data
      send_triple(BYTE_IAC, BYTE_WONT, 8'd0);
      send_byte(BYTE_IAC);
      send_byte(8'h10);
      // wont with dont carrying a value becomes a data triple
      send_triple(BYTE_IAC, BYTE_WONT, 8'd0);
      send_triple(BYTE_IAC, BYTE_DONT, 8'd5);
      // trailing partial word dropped at the end
      end_file();
   endtask

   task automatic send_random_text_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_byte(8'($urandom_range(254)));
      end else if (pick < 65) begin
         send_byte(BYTE_IAC);
         send_byte(8'($urandom_range(250)));
      end else if (pick < 80) begin
         send_triple(BYTE_IAC, 8'($urandom_range(255, 251)),
                     $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, 1)));
      end else if (pick < 83) begin
         send_byte(BYTE_IAC);
      end else begin
         send_triple(BYTE_IAC, BYTE_WILL, 8'd0);
      end
   endtask

   task automatic send_random_file_item();
      int pick;
      logic [7:0] b;
      pick = $urandom_range(99);
      b = 8'($urandom);
      if (pick < 70) begin
         send_byte(b);
         if (b == BYTE_IAC)
            send_byte(BYTE_IAC);
      end else if (pick < 77) begin
         end_file();
      end else if (pick < 86) begin
         // broken end-of-file sequence
         send_triple(BYTE_IAC, BYTE_WONT, 8'd0);
         case ($urandom_range(2))
            0: send_byte(8'($urandom_range(254)));
            1: begin
               if (b == BYTE_DONT)
                  b = BYTE_IAC;
               send_byte(BYTE_IAC);
               send_byte(b);
            end
            default: send_triple(BYTE_IAC, BYTE_DONT, 8'($urandom_range(255, 1)));
         endcase
      end else if (pick < 92) begin
         send_triple(BYTE_IAC, 8'($urandom_range(255, 251)), $urandom_range(1) ? 8'd0 : b);
      end else if (pick < 96) begin
         send_byte(BYTE_IAC);
         send_byte(8'($urandom_range(250)));
      end else begin
         send_byte(b);
      end
   endtask

   task automatic run_random_phase(input logic [31:0] base, input int idle_pct,
                                   input int stall_pct);
      int target;
      write_file_base(base);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
         if (in_binary)
            send_random_file_item();
         else
            send_random_text_item();
      end
      if (in_binary)
         end_file();
   endtask

   task automatic test_random_traffic();
      run_random_phase(32'd0, 0, 0);
      run_random_phase(32'hFFFF_FFFC, 80, 0);
      run_random_phase($urandom & 32'hFFFF_FFFC, 0, 80);
      run_random_phase(BASE_RESET, 37, 37);
   endtask

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset_receiver_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_text_path();
      test_reply_commands();
      test_binary_file();
      test_random_traffic();
      req_push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/tbfr_pkg.sv
src/tbfr_front.sv
src/tbfr_queue.sv
src/tbfr_back.sv
src/telnet_binary_file_receiver.sv
dv/tb.sv
